### sv/assert_macros.svh
// Assertion helpers shared by the tokenizer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check a property on every rising clock edge outside reset.
`define TT_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
		else $error("tokenizer assertion failed");

// Check that a condition never holds outside reset.
`define TT_ASSERT_NEVER(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) \
		else $error("tokenizer forbidden condition seen");

`else

`define TT_ASSERT(label, clk, rst_n, prop)
`define TT_ASSERT_NEVER(label, clk, rst_n, cond)

`endif

`endif

### sv/tt_pkg.sv
`default_nettype none

package tt_pkg;

	typedef enum logic [3:0] {
		KIND_END     = 4'd0,
		KIND_SEMI    = 4'd1,
		KIND_COLON   = 4'd2,
		KIND_STAR    = 4'd3,
		KIND_LPAREN  = 4'd4,
		KIND_RPAREN  = 4'd5,
		KIND_LBRACE  = 4'd6,
		KIND_RBRACE  = 4'd7,
		KIND_STRING  = 4'd8,
		KIND_IDENT   = 4'd9,
		KIND_UNKNOWN = 4'd10
	} kind_t;

	typedef struct packed {
		kind_t       kind;
		logic [15:0] start;
		logic [15:0] length;
		logic        last;
	} tok_t;

	// Tokens caused by one character: one, or two when a pending token closes and the character makes a token of its own.
	typedef struct packed {
		logic two;
		tok_t t0;
		tok_t t1;
	} pair_t;

	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = 2;

	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_SEMI   = 8'h3B;
	localparam logic [7:0] CH_COLON  = 8'h3A;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_LBRACE = 8'h7B;
	localparam logic [7:0] CH_RBRACE = 8'h7D;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_BSL    = 8'h5C;
	localparam logic [7:0] CH_UNDER  = 8'h5F;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_STAR   = 8'h2A;

	function automatic logic is_letter(input logic [7:0] c);
		return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return c >= 8'h30 && c <= 8'h39;
	endfunction

	function automatic logic is_eol(input logic [7:0] c);
		return c == 8'h0A || c == 8'h0D;
	endfunction

	function automatic logic is_space(input logic [7:0] c);
		return c == 8'h20 || c == 8'h09 || c == 8'h0B || c == 8'h0C || is_eol(c);
	endfunction

endpackage

`default_nettype wire

### sv/text_tokenizer.sv
`default_nettype none

// Character tokenizer. Push one character per cycle (0 ends the text); pop
// tokens in order: kind, start offset, length and a flag on the final token
// that a character caused. Whitespace and // and /* */ comments are
// skipped, strings report the raw text between the quotes, identifiers are
// a letter then letters, digits or underscores, ; : * ( ) { } and the 0
// each have their own kind, and every other character is a one-character
// unknown token. The edge that takes a character writes its tokens into
// the queue; the output register loads them once its previous tokens are
// popped. The front scanner accepts one character every cycle while the
// token queue (four entries, each holding the one or two tokens of one
// character) has room, and the back end delivers one token per cycle while
// the receiver pops, so sustained throughput is one character per cycle
// unless characters produce more than one token on average.
// Positions are counted on POSITION_WIDTH bits and saturate; reported
// start and length also saturate at 65535.
module text_tokenizer #(
	parameter int POSITION_WIDTH = 16
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	output logic               full,
	input  wire logic [7:0]    ch,
	output logic               empty,
	input  wire logic          pop,
	output logic [3:0]         token_kind,
	output logic [15:0]        token_start,
	output logic [15:0]        token_length,
	output logic               last_of_run
);

	logic            take;
	logic            q_wr, q_rd, q_empty;
	tt_pkg::pair_t   q_wdata, q_rdata;

	// Take a pushed character whenever the queue has a free entry.
	assign take = push & !full;

	tt_scanner #(
		.PW(POSITION_WIDTH)
	) u_scanner (
		.clk    (clk),
		.arst_n (arst_n),
		.take   (take),
		.ch     (ch),
		.pair   (q_wdata),
		.wr     (q_wr)
	);

	tt_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (q_wr),
		.wdata  (q_wdata),
		.full   (full),
		.rd     (q_rd),
		.rdata  (q_rdata),
		.empty  (q_empty)
	);

	tt_emitter u_emitter (
		.clk          (clk),
		.arst_n       (arst_n),
		.fifo_empty   (q_empty),
		.fifo_data    (q_rdata),
		.fifo_rd      (q_rd),
		.pop          (pop),
		.empty        (empty),
		.token_kind   (token_kind),
		.token_start  (token_start),
		.token_length (token_length),
		.last_of_run  (last_of_run)
	);

endmodule

`default_nettype wire

### sv/tt_scanner.sv
`default_nettype none

module tt_scanner #(
	parameter int PW = 16
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          take,
	input  wire logic [7:0]    ch,
	output tt_pkg::pair_t      pair,
	output logic               wr
);

	typedef enum logic [7:0] {
		ST_NORMAL = 8'b0000_0001,
		ST_SLASH  = 8'b0000_0010,
		ST_LINE   = 8'b0000_0100,
		ST_BLOCK  = 8'b0000_1000,
		ST_BSTAR  = 8'b0001_0000,
		ST_STR    = 8'b0010_0000,
		ST_ESC    = 8'b0100_0000,
		ST_IDENT  = 8'b1000_0000
	} state_t;

	state_t          state_q, nstate;
	logic [PW-1:0]   pos_q, start_q, len_q;
	logic [PW-1:0]   nstart, nlen;
	logic            pre_emit, b_emit, run_b;
	tt_pkg::tok_t    pre_tok, b_tok;

	function automatic logic [PW-1:0] sat_inc(input logic [PW-1:0] v);
		return (v == {PW{1'b1}}) ? v : v + PW'(1);
	endfunction

	function automatic logic [15:0] clamp16(input logic [PW-1:0] v);
		logic [31:0] e;
		e = 32'(v);
		return (e > 32'h0000_FFFF) ? 16'hFFFF : e[15:0];
	endfunction

	function automatic tt_pkg::tok_t mk_tok(input tt_pkg::kind_t k,
			input logic [PW-1:0] s, input logic [PW-1:0] l);
		tt_pkg::tok_t t;
		t.kind   = k;
		t.start  = clamp16(s);
		t.length = clamp16(l);
		t.last   = 1'b0;
		return t;
	endfunction

	always_comb begin
		pre_emit = 1'b0;
		pre_tok  = '0;
		run_b    = 1'b0;
		nstate   = state_q;
		nstart   = start_q;
		nlen     = len_q;
		unique case (state_q)
			ST_SLASH: begin
				if (ch == tt_pkg::CH_SLASH) begin
					nstate = ST_LINE;
				end else if (ch == tt_pkg::CH_STAR) begin
					nstate = ST_BLOCK;
				end else begin
					pre_emit = 1'b1;
					pre_tok  = mk_tok(tt_pkg::KIND_UNKNOWN, start_q, PW'(1));
					run_b    = 1'b1;
				end
			end
			ST_LINE: begin
				if (ch == tt_pkg::CH_NUL || tt_pkg::is_eol(ch)) begin
					run_b = 1'b1;
				end
			end
			ST_BLOCK, ST_BSTAR: begin
				if (ch == tt_pkg::CH_NUL) begin
					run_b = 1'b1;
				end else if (state_q == ST_BSTAR && ch == tt_pkg::CH_SLASH) begin
					nstate = ST_NORMAL;
				end else begin
					nstate = (ch == tt_pkg::CH_STAR) ? ST_BSTAR : ST_BLOCK;
				end
			end
			ST_STR: begin
				if (ch == tt_pkg::CH_NUL || ch == tt_pkg::CH_QUOTE) begin
					pre_emit = 1'b1;
					pre_tok  = mk_tok(tt_pkg::KIND_STRING, start_q, len_q);
					nstate   = ST_NORMAL;
					run_b    = (ch == tt_pkg::CH_NUL);
				end else begin
					nlen = sat_inc(len_q);
					if (ch == tt_pkg::CH_BSL) begin
						nstate = ST_ESC;
					end
				end
			end
			ST_ESC: begin
				if (ch == tt_pkg::CH_NUL) begin
					pre_emit = 1'b1;
					pre_tok  = mk_tok(tt_pkg::KIND_STRING, start_q, len_q);
					run_b    = 1'b1;
				end else begin
					nlen   = sat_inc(len_q);
					nstate = ST_STR;
				end
			end
			ST_IDENT: begin
				if (tt_pkg::is_letter(ch) || tt_pkg::is_digit(ch) || ch == tt_pkg::CH_UNDER) begin
					nlen = sat_inc(len_q);
				end else begin
					pre_emit = 1'b1;
					pre_tok  = mk_tok(tt_pkg::KIND_IDENT, start_q, len_q);
					run_b    = 1'b1;
				end
			end
			default: begin
				run_b = 1'b1;
			end
		endcase

		// Between tokens: skip whitespace, start a pending token or emit a short one.
		b_emit = 1'b0;
		b_tok  = '0;
		if (run_b) begin
			nstate = ST_NORMAL;
			if (!tt_pkg::is_space(ch)) begin
				b_emit = 1'b1;
				unique case (ch)
					tt_pkg::CH_NUL:    b_tok = mk_tok(tt_pkg::KIND_END, pos_q, PW'(1));
					tt_pkg::CH_SEMI:   b_tok = mk_tok(tt_pkg::KIND_SEMI, pos_q, PW'(1));
					tt_pkg::CH_COLON:  b_tok = mk_tok(tt_pkg::KIND_COLON, pos_q, PW'(1));
					tt_pkg::CH_STAR:   b_tok = mk_tok(tt_pkg::KIND_STAR, pos_q, PW'(1));
					tt_pkg::CH_LPAREN: b_tok = mk_tok(tt_pkg::KIND_LPAREN, pos_q, PW'(1));
					tt_pkg::CH_RPAREN: b_tok = mk_tok(tt_pkg::KIND_RPAREN, pos_q, PW'(1));
					tt_pkg::CH_LBRACE: b_tok = mk_tok(tt_pkg::KIND_LBRACE, pos_q, PW'(1));
					tt_pkg::CH_RBRACE: b_tok = mk_tok(tt_pkg::KIND_RBRACE, pos_q, PW'(1));
					tt_pkg::CH_SLASH: begin
						b_emit = 1'b0;
						nstate = ST_SLASH;
						nstart = pos_q;
						nlen   = PW'(1);
					end
					tt_pkg::CH_QUOTE: begin
						b_emit = 1'b0;
						nstate = ST_STR;
						nstart = sat_inc(pos_q);
						nlen   = '0;
					end
					default: begin
						if (tt_pkg::is_letter(ch)) begin
							b_emit = 1'b0;
							nstate = ST_IDENT;
							nstart = pos_q;
							nlen   = PW'(1);
						end else begin
							b_tok = mk_tok(tt_pkg::KIND_UNKNOWN, pos_q, PW'(1));
						end
					end
				endcase
			end
		end

		pair.two     = pre_emit & b_emit;
		pair.t0      = pre_emit ? pre_tok : b_tok;
		pair.t0.last = !(pre_emit & b_emit);
		pair.t1      = b_tok;
		pair.t1.last = 1'b1;
		wr           = take & (pre_emit | b_emit);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_NORMAL;
			pos_q   <= '0;
			start_q <= '0;
			len_q   <= '0;
		end else if (take) begin
			state_q <= nstate;
			start_q <= nstart;
			len_q   <= nlen;
			pos_q   <= (ch == tt_pkg::CH_NUL) ? '0 : sat_inc(pos_q);
		end
	end

endmodule

`default_nettype wire

### sv/tt_fifo.sv
`default_nettype none

`include "assert_macros.svh"

module tt_fifo (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            wr,
	input  wire tt_pkg::pair_t   wdata,
	output logic                 full,
	input  wire logic            rd,
	output tt_pkg::pair_t        rdata,
	output logic                 empty
);

	tt_pkg::pair_t                 mem_q [tt_pkg::FIFO_DEPTH];
	logic [tt_pkg::FIFO_AW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [tt_pkg::FIFO_AW:0]      count_q;

	assign full  = (count_q == (tt_pkg::FIFO_AW + 1)'(tt_pkg::FIFO_DEPTH));
	assign empty = (count_q == '0);
	assign rdata = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (rd) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (wr && !rd) begin
				count_q <= count_q + 1'b1;
			end else if (rd && !wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	`TT_ASSERT_NEVER(a_no_write_when_full, clk, arst_n, wr && full)
	`TT_ASSERT_NEVER(a_no_read_when_empty, clk, arst_n, rd && empty)
	`TT_ASSERT(a_count_grows, clk, arst_n, (wr && !rd) |=> (count_q == $past(count_q) + 1'b1))

endmodule

`default_nettype wire

### sv/tt_emitter.sv
`default_nettype none

`include "assert_macros.svh"

module tt_emitter (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            fifo_empty,
	input  wire tt_pkg::pair_t   fifo_data,
	output logic                 fifo_rd,
	input  wire logic            pop,
	output logic                 empty,
	output logic [3:0]           token_kind,
	output logic [15:0]          token_start,
	output logic [15:0]          token_length,
	output logic                 last_of_run
);

	logic            valid_q, idx_q;
	tt_pkg::pair_t   pair_q;
	tt_pkg::tok_t    cur;
	logic            fire, done, load;

	assign cur          = idx_q ? pair_q.t1 : pair_q.t0;
	assign empty        = !valid_q;
	assign token_kind   = cur.kind;
	assign token_start  = cur.start;
	assign token_length = cur.length;
	assign last_of_run  = cur.last;

	assign fire    = pop & valid_q;
	assign done    = fire & (idx_q | !pair_q.two);
	assign load    = !valid_q | done;
	assign fifo_rd = load & !fifo_empty;

	// Hold the pair while its tokens drain; refill as the last one leaves or while empty.
	always_ff @(posedge clk) begin
		if (fifo_rd) begin
			pair_q <= fifo_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= 1'b0;
		end else if (load) begin
			valid_q <= !fifo_empty;
			idx_q   <= 1'b0;
		end else if (fire) begin
			idx_q <= 1'b1;
		end
	end

	`TT_ASSERT(a_second_only_in_pair, clk, arst_n, (valid_q && idx_q) |-> pair_q.two)
	`TT_ASSERT(a_stall_holds_token, clk, arst_n,
		(valid_q && !pop) |=> (valid_q && $stable(idx_q)))
	`TT_ASSERT(a_last_on_second, clk, arst_n, (valid_q && idx_q) |-> last_of_run)

endmodule

`default_nettype wire

### tb/tokenizer_checker.sv
module tokenizer_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  logic        full,
	input  logic [7:0]  ch,
	input  logic        empty,
	input  logic        pop,
	input  logic [3:0]  token_kind,
	input  logic [15:0] token_start,
	input  logic [15:0] token_length,
	input  logic        last_of_run,
	output int          mismatches,
	output int          waiting
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int POSITION_WIDTH = 16;
	localparam int REPORT_LIMIT   = 10;

	localparam logic [7:0] CH_TAB = 8'h09;
	localparam logic [7:0] CH_LF  = 8'h0A;
	localparam logic [7:0] CH_VT  = 8'h0B;
	localparam logic [7:0] CH_FF  = 8'h0C;
	localparam logic [7:0] CH_CR  = 8'h0D;
	localparam logic [7:0] CH_SP  = 8'h20;

	typedef logic [POSITION_WIDTH-1:0] pos_t;
	localparam pos_t POS_LIMIT = '1;
	localparam pos_t POS_ONE   = pos_t'(1);

	typedef enum logic [2:0] {
		MODE_IDLE,
		MODE_SLASH,
		MODE_LINE,
		MODE_BLOCK,
		MODE_BLOCK_STAR,
		MODE_STRING,
		MODE_STRING_ESC,
		MODE_IDENT
	} scan_mode_t;

	scan_mode_t     mode;
	pos_t           next_pos;
	pos_t           tok_begin;
	pos_t           tok_len;
	tt_pkg::tok_t   expected_tokens[$];
	tt_pkg::tok_t   char_tokens[$];

	function automatic pos_t bump(pos_t v);
		return (v == POS_LIMIT) ? v : v + 1'b1;
	endfunction

	function automatic logic [15:0] clamp16(pos_t v);
		return (32'(v) > 32'd65535) ? 16'hFFFF : 16'(v);
	endfunction

	function automatic logic alpha(logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
	endfunction

	function automatic logic numeral(logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic logic line_end(logic [7:0] c);
		return c == CH_LF || c == CH_CR;
	endfunction

	function automatic logic blank(logic [7:0] c);
		return c == CH_SP || c == CH_TAB || c == CH_VT || c == CH_FF || line_end(c);
	endfunction

	task automatic note_token(tt_pkg::kind_t k, pos_t s, pos_t len);
		tt_pkg::tok_t t;
		t.kind   = k;
		t.start  = clamp16(s);
		t.length = clamp16(len);
		t.last   = 1'b0;
		if (char_tokens.size() < 2)
			char_tokens.push_back(t);
	endtask

	// Character seen with no token open.
	task automatic scan_fresh(logic [7:0] c, pos_t pos);
		mode = MODE_IDLE;
		if (blank(c))
			return;
		case (c)
		tt_pkg::CH_NUL:    note_token(tt_pkg::KIND_END, pos, POS_ONE);
		tt_pkg::CH_SEMI:   note_token(tt_pkg::KIND_SEMI, pos, POS_ONE);
		tt_pkg::CH_COLON:  note_token(tt_pkg::KIND_COLON, pos, POS_ONE);
		tt_pkg::CH_STAR:   note_token(tt_pkg::KIND_STAR, pos, POS_ONE);
		tt_pkg::CH_LPAREN: note_token(tt_pkg::KIND_LPAREN, pos, POS_ONE);
		tt_pkg::CH_RPAREN: note_token(tt_pkg::KIND_RPAREN, pos, POS_ONE);
		tt_pkg::CH_LBRACE: note_token(tt_pkg::KIND_LBRACE, pos, POS_ONE);
		tt_pkg::CH_RBRACE: note_token(tt_pkg::KIND_RBRACE, pos, POS_ONE);
		tt_pkg::CH_SLASH: begin
			mode      = MODE_SLASH;
			tok_begin = pos;
			tok_len   = POS_ONE;
		end
		tt_pkg::CH_QUOTE: begin
			mode      = MODE_STRING;
			tok_begin = bump(pos);
			tok_len   = '0;
		end
		default: begin
			if (alpha(c)) begin
				mode      = MODE_IDENT;
				tok_begin = pos;
				tok_len   = POS_ONE;
			end else begin
				note_token(tt_pkg::KIND_UNKNOWN, pos, POS_ONE);
			end
		end
		endcase
	endtask

	task automatic predict_char(logic [7:0] c);
		pos_t pos;
		pos = next_pos;
		char_tokens.delete();
		case (mode)
		MODE_SLASH: begin
			if (c == tt_pkg::CH_SLASH) begin
				mode = MODE_LINE;
			end else if (c == tt_pkg::CH_STAR) begin
				mode = MODE_BLOCK;
			end else begin
				note_token(tt_pkg::KIND_UNKNOWN, tok_begin, POS_ONE);
				scan_fresh(c, pos);
			end
		end
		MODE_LINE: begin
			if (c == tt_pkg::CH_NUL || line_end(c))
				scan_fresh(c, pos);
		end
		MODE_BLOCK, MODE_BLOCK_STAR: begin
			if (c == tt_pkg::CH_NUL)
				scan_fresh(c, pos);
			else if (mode == MODE_BLOCK_STAR && c == tt_pkg::CH_SLASH)
				mode = MODE_IDLE;
			else
				mode = (c == tt_pkg::CH_STAR) ? MODE_BLOCK_STAR : MODE_BLOCK;
		end
		MODE_STRING: begin
			if (c == tt_pkg::CH_NUL || c == tt_pkg::CH_QUOTE) begin
				note_token(tt_pkg::KIND_STRING, tok_begin, tok_len);
				mode = MODE_IDLE;
				if (c == tt_pkg::CH_NUL)
					scan_fresh(c, pos);
			end else begin
				tok_len = bump(tok_len);
				if (c == tt_pkg::CH_BSL)
					mode = MODE_STRING_ESC;
			end
		end
		MODE_STRING_ESC: begin
			if (c == tt_pkg::CH_NUL) begin
				note_token(tt_pkg::KIND_STRING, tok_begin, tok_len);
				scan_fresh(c, pos);
			end else begin
				tok_len = bump(tok_len);
				mode    = MODE_STRING;
			end
		end
		MODE_IDENT: begin
			if (alpha(c) || numeral(c) || c == tt_pkg::CH_UNDER) begin
				tok_len = bump(tok_len);
			end else begin
				note_token(tt_pkg::KIND_IDENT, tok_begin, tok_len);
				scan_fresh(c, pos);
			end
		end
		default: scan_fresh(c, pos);
		endcase
		if (char_tokens.size() > 0)
			char_tokens[char_tokens.size() - 1].last = 1'b1;
		foreach (char_tokens[i])
			expected_tokens.push_back(char_tokens[i]);
		next_pos = (c == tt_pkg::CH_NUL) ? '0 : bump(next_pos);
	endtask

	task automatic check_token();
		tt_pkg::tok_t want;
		if (expected_tokens.size() == 0) begin
			mismatches++;
			if (mismatches <= REPORT_LIMIT)
				$display("%0t: unexpected token kind %0d start %0d length %0d last %0b",
					$realtime, token_kind, token_start, token_length, last_of_run);
			return;
		end
		want = expected_tokens.pop_front();
		if (token_kind !== want.kind || token_start !== want.start ||
				token_length !== want.length || last_of_run !== want.last) begin
			mismatches++;
			if (mismatches <= REPORT_LIMIT)
				$display("%0t: token mismatch: expected kind %0d start %0d length %0d last %0b, %s",
					$realtime, want.kind, want.start, want.length, want.last,
					$sformatf("got kind %0d start %0d length %0d last %0b",
						token_kind, token_start, token_length, last_of_run));
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode       = MODE_IDLE;
			next_pos   = '0;
			tok_begin  = '0;
			tok_len    = '0;
			mismatches = 0;
			expected_tokens.delete();
			waiting <= 0;
		end else begin
			if (pop && !empty)
				check_token();
			if (push && !full)
				predict_char(ch);
			waiting <= expected_tokens.size();
		end
	end

endmodule

### tb/testbench.sv
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	// Cycles with no item moving on either side before the run is called hung.
	// The longest honest quiet stretch is a sender gap plus a slow-drain stall.
	localparam int STALL_LIMIT  = 2000;
	localparam int RANDOM_CHARS = 1000;
	// A long identifier, well past the lengths that the random pieces make.
	localparam int LONG_WORD    = 60;
	localparam int SETTLE       = 20;

	typedef enum logic [1:0] {
		DRAIN_FREE,
		DRAIN_RANDOM,
		DRAIN_SLOW
	} drain_mode_t;

	logic        clk    = 1'b0;
	logic        arst_n = 1'b0;
	logic        push   = 1'b0;
	logic [7:0]  ch     = 8'h00;
	logic        pop    = 1'b0;
	logic        full;
	logic        empty;
	logic [3:0]  token_kind;
	logic [15:0] token_start;
	logic [15:0] token_length;
	logic        last_of_run;
	int          mismatches;
	int          waiting;

	int          burst_left = 0;
	int          sent_chars = 0;
	int          quiet_cycles = 0;
	drain_mode_t drain_mode = DRAIN_FREE;
	int          drain_left = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	text_tokenizer u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.ch           (ch),
		.empty        (empty),
		.pop          (pop),
		.token_kind   (token_kind),
		.token_start  (token_start),
		.token_length (token_length),
		.last_of_run  (last_of_run)
	);

	tokenizer_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.ch           (ch),
		.empty        (empty),
		.pop          (pop),
		.token_kind   (token_kind),
		.token_start  (token_start),
		.token_length (token_length),
		.last_of_run  (last_of_run),
		.mismatches   (mismatches),
		.waiting      (waiting)
	);

	// Hold push low while n counts down; scribble on ch so an idle input is seen ignored.
	task automatic hold_off(int n);
		repeat (n) begin
			@(negedge clk);
			push <= 1'b0;
			ch   <= 8'($urandom);
		end
	endtask

	// Offer one item and return right after the edge that takes it.
	// Bursts of random length are split by random gaps, some of them zero,
	// so gaps land on every scanner mode.
	task automatic send_char(logic [7:0] c);
		if (burst_left == 0) begin
			if ($urandom_range(0, 3) != 0)
				hold_off($urandom_range(1, 12));
			burst_left = $urandom_range(1, 40);
		end
		burst_left--;
		sent_chars++;
		@(negedge clk);
		push <= 1'b1;
		ch   <= c;
		@(posedge clk);
		while (full)
			@(posedge clk);
	endtask

	task automatic send_text(string s);
		for (int i = 0; i < s.len(); i++)
			send_char(s[i]);
	endtask

	// Stop sending and wait until every predicted token has been popped.
	task automatic drain_all();
		hold_off(1);
		while (waiting != 0)
			@(posedge clk);
	endtask

	function automatic logic [7:0] rand_letter();
		return ($urandom_range(0, 1) == 0) ? "a" + 8'($urandom_range(0, 25))
			: "A" + 8'($urandom_range(0, 25));
	endfunction

	function automatic logic [7:0] rand_word_char();
		case ($urandom_range(0, 3))
		0: return "0" + 8'($urandom_range(0, 9));
		1: return tt_pkg::CH_UNDER;
		default: return rand_letter();
		endcase
	endfunction

	function automatic logic [7:0] rand_punct();
		case ($urandom_range(0, 6))
		0: return tt_pkg::CH_SEMI;
		1: return tt_pkg::CH_COLON;
		2: return tt_pkg::CH_STAR;
		3: return tt_pkg::CH_LPAREN;
		4: return tt_pkg::CH_RPAREN;
		5: return tt_pkg::CH_LBRACE;
		default: return tt_pkg::CH_RBRACE;
		endcase
	endfunction

	function automatic logic [7:0] rand_blank();
		case ($urandom_range(0, 5))
		0: return 8'h09;
		1: return 8'h0A;
		2: return 8'h0B;
		3: return 8'h0C;
		4: return 8'h0D;
		default: return 8'h20;
		endcase
	endfunction

	// One lexical piece: mostly well-formed tokens and comments with random
	// content, plus noise, stray slashes, open strings and end-of-text marks.
	task automatic send_fragment();
		logic [7:0] c;
		int         n;
		case ($urandom_range(0, 11))
		0, 1: begin
			send_char(rand_letter());
			n = ($urandom_range(0, 15) == 0) ? $urandom_range(8, 40) : $urandom_range(0, 7);
			repeat (n)
				send_char(rand_word_char());
		end
		2: begin
			send_char(tt_pkg::CH_QUOTE);
			repeat ($urandom_range(0, 6)) begin
				if ($urandom_range(0, 3) == 0) begin
					send_char(tt_pkg::CH_BSL);
					send_char(8'($urandom_range(1, 255)));
				end else begin
					c = 8'($urandom_range(1, 255));
					send_char((c == tt_pkg::CH_QUOTE || c == tt_pkg::CH_BSL) ? "x" : c);
				end
			end
			// leave a few strings open so later pieces run inside them
			if ($urandom_range(0, 7) != 0)
				send_char(tt_pkg::CH_QUOTE);
		end
		3: begin
			send_text("//");
			repeat ($urandom_range(0, 8)) begin
				c = 8'($urandom_range(1, 255));
				send_char((c == 8'h0A || c == 8'h0D) ? "-" : c);
			end
			send_char(($urandom_range(0, 1) == 0) ? 8'h0A : 8'h0D);
		end
		4: begin
			send_text("/*");
			repeat ($urandom_range(0, 8))
				send_char(($urandom_range(0, 3) == 0) ? tt_pkg::CH_STAR
					: 8'($urandom_range(1, 255)));
			send_text("*/");
		end
		5, 6: send_char(rand_punct());
		7: repeat ($urandom_range(1, 3)) send_char(rand_blank());
		8: begin
			send_char(tt_pkg::CH_SLASH);
			send_char(8'($urandom_range(0, 255)));
		end
		9: send_char(8'($urandom_range(1, 255)));
		10: send_char(tt_pkg::CH_NUL);
		default: send_char(($urandom_range(0, 1) == 0) ? tt_pkg::CH_UNDER
			: "0" + 8'($urandom_range(0, 9)));
		endcase
	endtask

	// Receiver: switch between popping every cycle, popping at random and
	// popping rarely, each for a random stretch, so the token queue fills up.
	always @(negedge clk) begin
		if (drain_left == 0) begin
			drain_mode = drain_mode_t'($urandom_range(0, 2));
			drain_left = $urandom_range(4, 40);
		end
		drain_left--;
		case (drain_mode)
		DRAIN_FREE:   pop <= 1'b1;
		DRAIN_RANDOM: pop <= 1'($urandom_range(0, 1));
		default:      pop <= ($urandom_range(0, 7) == 0);
		endcase
	end

	// Watchdog: count cycles in which nothing moves on either side.
	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("text_tokenizer regression: fail");
			$finish;
		end
	end

	initial begin
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Identifier closed by a paren: two tokens from one character.
		send_text("zA9_(");
		// Lone slash flushed by the next token.
		send_text("/)");
		// Open string with an escape, cut off by end of text right after a backslash.
		send_text("\"a\\");
		send_char(tt_pkg::CH_NUL);
		// The opener's star must not close the comment.
		send_text("/*/*/;");
		send_text("//x\n");
		send_char(8'hFF);
		// Lone slash still pending at end of text.
		send_char(tt_pkg::CH_SLASH);
		send_char(tt_pkg::CH_NUL);
		drain_all();

		// Send one long identifier, then end the text.
		send_char(rand_letter());
		repeat (LONG_WORD)
			send_char(rand_word_char());
		send_char(tt_pkg::CH_SEMI);
		send_char(tt_pkg::CH_NUL);
		drain_all();

		sent_chars = 0;
		while (sent_chars < RANDOM_CHARS / 2)
			send_fragment();
		// Pause the sender once with nothing left in flight.
		drain_all();
		while (sent_chars < RANDOM_CHARS)
			send_fragment();

		drain_all();
		repeat (SETTLE) @(posedge clk);
		if (mismatches == 0 && waiting == 0)
			$display("text_tokenizer regression: pass");
		else
			$display("text_tokenizer regression: fail");
		$finish;
	end

endmodule
